// ===== rtl/core/link_busy_time_per_interval_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the link busy time core
// Two small wrappers around concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef LINK_BUSY_TIME_PER_INTERVAL_CORE_ASSERT_SVH
`define LINK_BUSY_TIME_PER_INTERVAL_CORE_ASSERT_SVH

// Same-cycle implication.
`define LBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LBT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lbt_pkg.sv =====
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared widths, codes, types and the saturating busy-time update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbt_pkg;

   localparam int TIME_W = 63;
   localparam int BUSY_W = 40;
   localparam int WEND_W = 64;
   localparam int MAX_RECORDS_DEF = 64;

   localparam logic [BUSY_W-1:0] RESET_INTERVAL = 40'd100000000;

   localparam logic [1:0] MODE_TX_BEGIN = 2'd0;
   localparam logic [1:0] MODE_TX_END   = 2'd1;
   localparam logic [1:0] MODE_TICK     = 2'd2;
   localparam logic [1:0] MODE_FINALIZE = 2'd3;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [BUSY_W-1:0] busy_type;
   typedef logic [WEND_W-1:0] wend_type;

   typedef struct packed {
      logic     start;
      time_type dividend;
      busy_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      busy_type rem;
   } div_rsp_type;

   // Adds the span from..to to the busy counter when transmitting, saturating.
   function automatic busy_type busy_add(busy_type acc, logic tx, wend_type from,
                                         wend_type to);
      wend_type d;
      logic [BUSY_W:0] s;
      busy_type r;
      d = to - from;
      s = {1'b0, acc} + {1'b0, d[BUSY_W-1:0]};
      if (!tx || (to <= from)) begin
         r = acc;
      end else if ((d[WEND_W-1:BUSY_W] != '0) || s[BUSY_W]) begin
         r = '1;
      end else begin
         r = s[BUSY_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/lbt_rem_div.sv =====
// ----------------------------------------------------------------------------
// lbt_rem_div
// Bit-serial restoring divider that returns only the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbt_rem_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lbt_pkg::div_req_type div_req,
   output lbt_pkg::div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(lbt_pkg::TIME_W);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   lbt_pkg::time_type      dvd_ff, dvd_in;
   lbt_pkg::busy_type      dvs_ff, dvs_in;
   lbt_pkg::busy_type      rem_ff, rem_in;
   logic [lbt_pkg::BUSY_W:0] trial;
   logic [lbt_pkg::BUSY_W:0] diff;

   // One quotient bit per cycle; the partial remainder stays below the divisor.
   always_comb begin
      trial   = {rem_ff, dvd_ff[lbt_pkg::TIME_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(lbt_pkg::TIME_W - 1);
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
      end else if (run_ff) begin
         rem_in = (trial >= {1'b0, dvs_ff}) ? diff[lbt_pkg::BUSY_W-1:0]
                                            : trial[lbt_pkg::BUSY_W-1:0];
         dvd_in = {dvd_ff[lbt_pkg::TIME_W-2:0], 1'b0};
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

// ===== rtl/core/link_busy_time_per_interval_core.sv =====
// ----------------------------------------------------------------------------
// link_busy_time_per_interval_core
// Accumulates link transmit time per reporting interval and emits one
// record per crossed interval boundary, plus a partial record on finalize.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Beat contents
//   --------+-----------+--------------------+--------------------------------
//   req     | in        | req_valid/ready    | mode, now_ns
//   rsp     | out       | rsp_valid/ready    | interval bounds, busy, flags
//   csr     | in        | csr_wr_en (no wait)| interval length
//
// An event is accepted only while the sequencer is idle. It then passes
// through S_BOUND, one boundary record at a time, then S_TAIL and S_FLUSH
// before the next event is taken. An event that crosses more boundaries
// than MAX_RECORDS allows goes through S_DIV: a bit-serial remainder divider
// (one bit per cycle over the 63-bit time span) locates the current interval.
// Reset is synchronous and active high; the block comes out of it ready.
// A stalled response holds the sequencer only when a record has to move out
// of the hold register while the output register is still occupied.
//
// Each record is parked in a hold register until the sequencer knows whether
// another record of the same event follows; only then is its last flag (and
// the dropped flag) known, and it moves into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "link_busy_time_per_interval_core_assert.svh"

module link_busy_time_per_interval_core #(
   parameter int MAX_RECORDS = lbt_pkg::MAX_RECORDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Event input
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_mode,
   input  logic [lbt_pkg::TIME_W-1:0] req_now_ns,
   // Record output
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lbt_pkg::TIME_W-1:0] rsp_interval_start_ns,
   output logic [lbt_pkg::TIME_W-1:0] rsp_interval_end_ns,
   output logic [lbt_pkg::BUSY_W-1:0] rsp_busy_ns,
   output logic                      rsp_is_partial,
   output logic                      rsp_dropped,
   output logic                      rsp_last,
   // Configuration
   input  logic                      csr_wr_en,
   input  logic [lbt_pkg::BUSY_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam logic [CNT_W-1:0] CAP_EVENT    = CNT_W'(MAX_RECORDS);
   localparam logic [CNT_W-1:0] CAP_FINALIZE = CNT_W'(MAX_RECORDS - 1);
   localparam int PAD_W = lbt_pkg::WEND_W - lbt_pkg::BUSY_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BOUND = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_TAIL  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]         state_ff, state_in;

   // Architectural state.
   lbt_pkg::busy_type  interval_ff, interval_in;
   lbt_pkg::time_type  prev_ff, prev_in;
   lbt_pkg::time_type  ws_ff, ws_in;
   lbt_pkg::wend_type  we_ff, we_in;
   lbt_pkg::busy_type  busy_ff, busy_in;
   logic               line_tx_ff, line_tx_in;

   // Per-event working registers.
   logic [1:0]         mode_ff, mode_in;
   lbt_pkg::time_type  now_ff, now_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               skipped_ff, skipped_in;

   // Hold register for the most recent record of the event.
   logic               hold_valid_ff, hold_valid_in;
   lbt_pkg::time_type  hold_start_ff, hold_start_in;
   lbt_pkg::time_type  hold_end_ff, hold_end_in;
   lbt_pkg::busy_type  hold_busy_ff, hold_busy_in;
   logic               hold_partial_ff, hold_partial_in;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   lbt_pkg::time_type  out_start_ff, out_start_in;
   lbt_pkg::time_type  out_end_ff, out_end_in;
   lbt_pkg::busy_type  out_busy_ff, out_busy_in;
   logic               out_partial_ff, out_partial_in;
   logic               out_dropped_ff, out_dropped_in;
   logic               out_last_ff, out_last_in;

   lbt_pkg::div_req_type div_req;
   lbt_pkg::div_rsp_type div_rsp;

   logic               seq_idle;
   logic               out_free;
   logic               reach;
   logic [CNT_W-1:0]   cap;
   lbt_pkg::busy_type  bound_busy;
   lbt_pkg::busy_type  tail_busy;
   logic               want_partial;
   lbt_pkg::wend_type  wend_expect;
   lbt_pkg::wend_type  span;
   lbt_pkg::busy_type  csr_interval;

   lbt_rem_div u_rem_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign seq_idle  = (state_ff == S_IDLE);
   assign req_ready = seq_idle;
   assign out_free  = !out_valid_ff || rsp_ready;

   // Between events the window end sits one interval after its start.
   assign wend_expect = {1'b0, ws_ff} + {{PAD_W{1'b0}}, interval_ff};

   always_comb begin
      state_in        = state_ff;
      interval_in     = interval_ff;
      prev_in         = prev_ff;
      ws_in           = ws_ff;
      we_in           = we_ff;
      busy_in         = busy_ff;
      line_tx_in      = line_tx_ff;
      mode_in         = mode_ff;
      now_in          = now_ff;
      count_in        = count_ff;
      skipped_in      = skipped_ff;
      hold_valid_in   = hold_valid_ff;
      hold_start_in   = hold_start_ff;
      hold_end_in     = hold_end_ff;
      hold_busy_in    = hold_busy_ff;
      hold_partial_in = hold_partial_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_start_in    = out_start_ff;
      out_end_in      = out_end_ff;
      out_busy_in     = out_busy_ff;
      out_partial_in  = out_partial_ff;
      out_dropped_in  = out_dropped_ff;
      out_last_in     = out_last_ff;

      reach        = ({1'b0, now_ff} >= we_ff);
      cap          = (mode_ff == lbt_pkg::MODE_FINALIZE) ? CAP_FINALIZE : CAP_EVENT;
      bound_busy   = lbt_pkg::busy_add(busy_ff, line_tx_ff, {1'b0, prev_ff}, we_ff);
      tail_busy    = lbt_pkg::busy_add(busy_ff, line_tx_ff, {1'b0, prev_ff},
                                       {1'b0, now_ff});
      want_partial = (mode_ff == lbt_pkg::MODE_FINALIZE) && (now_ff != ws_ff);
      span         = {1'b0, now_ff} - we_ff;
      csr_interval = (csr_wr_data == '0) ? lbt_pkg::BUSY_W'(1) : csr_wr_data;

      div_req.start    = 1'b0;
      div_req.dividend = span[lbt_pkg::TIME_W-1:0];
      div_req.divisor  = interval_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in    = req_mode;
               // Time never runs backwards.
               now_in     = (req_now_ns < prev_ff) ? prev_ff : req_now_ns;
               count_in   = '0;
               skipped_in = 1'b0;
               state_in   = S_BOUND;
            end
         end
         S_BOUND: begin
            if (reach && (count_ff < cap)) begin
               // Emit the closed window; any earlier record of this event
               // moves on to the output register as a non-final record.
               if (!hold_valid_ff || out_free) begin
                  if (hold_valid_ff) begin
                     out_valid_in   = 1'b1;
                     out_start_in   = hold_start_ff;
                     out_end_in     = hold_end_ff;
                     out_busy_in    = hold_busy_ff;
                     out_partial_in = hold_partial_ff;
                     out_dropped_in = 1'b0;
                     out_last_in    = 1'b0;
                  end
                  hold_valid_in   = 1'b1;
                  hold_start_in   = ws_ff;
                  hold_end_in     = we_ff[lbt_pkg::TIME_W-1:0];
                  hold_busy_in    = bound_busy;
                  hold_partial_in = 1'b0;
                  busy_in         = '0;
                  prev_in         = we_ff[lbt_pkg::TIME_W-1:0];
                  ws_in           = we_ff[lbt_pkg::TIME_W-1:0];
                  we_in           = we_ff + {{PAD_W{1'b0}}, interval_ff};
                  count_in        = count_ff + 1'b1;
               end
            end else if (reach) begin
               // Record budget spent: locate the window holding now by its
               // offset, now - ((now - window_end) mod interval).
               skipped_in    = 1'b1;
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               ws_in    = now_ff - {{(lbt_pkg::TIME_W - lbt_pkg::BUSY_W){1'b0}}, div_rsp.rem};
               prev_in  = ws_in;
               busy_in  = '0;
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (!want_partial || !hold_valid_ff || out_free) begin
               busy_in = tail_busy;
               prev_in = now_ff;
               if (skipped_ff) begin
                  we_in = wend_expect;
               end
               if (mode_ff == lbt_pkg::MODE_TX_BEGIN) begin
                  line_tx_in = 1'b1;
               end else if (mode_ff == lbt_pkg::MODE_TX_END) begin
                  line_tx_in = 1'b0;
               end
               if (want_partial) begin
                  if (hold_valid_ff) begin
                     out_valid_in   = 1'b1;
                     out_start_in   = hold_start_ff;
                     out_end_in     = hold_end_ff;
                     out_busy_in    = hold_busy_ff;
                     out_partial_in = hold_partial_ff;
                     out_dropped_in = 1'b0;
                     out_last_in    = 1'b0;
                  end
                  // The partial record does not clear the busy counter.
                  hold_valid_in   = 1'b1;
                  hold_start_in   = ws_ff;
                  hold_end_in     = now_ff;
                  hold_busy_in    = tail_busy;
                  hold_partial_in = 1'b1;
               end
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // The held record is the event's final one.
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in   = 1'b1;
               out_start_in   = hold_start_ff;
               out_end_in     = hold_end_ff;
               out_busy_in    = hold_busy_ff;
               out_partial_in = hold_partial_ff;
               out_dropped_in = skipped_ff;
               out_last_in    = 1'b1;
               hold_valid_in  = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Writes must come only when idle (unenforced); they re-time the window.
      if (csr_wr_en) begin
         interval_in = csr_interval;
         we_in       = {1'b0, ws_ff} + {{PAD_W{1'b0}}, csr_interval};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         interval_ff   <= lbt_pkg::RESET_INTERVAL;
         prev_ff       <= '0;
         ws_ff         <= '0;
         we_ff         <= {{PAD_W{1'b0}}, lbt_pkg::RESET_INTERVAL};
         busy_ff       <= '0;
         line_tx_ff    <= 1'b0;
         count_ff      <= '0;
         skipped_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         interval_ff   <= interval_in;
         prev_ff       <= prev_in;
         ws_ff         <= ws_in;
         we_ff         <= we_in;
         busy_ff       <= busy_in;
         line_tx_ff    <= line_tx_in;
         count_ff      <= count_in;
         skipped_ff    <= skipped_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      mode_ff         <= mode_in;
      now_ff          <= now_in;
      hold_start_ff   <= hold_start_in;
      hold_end_ff     <= hold_end_in;
      hold_busy_ff    <= hold_busy_in;
      hold_partial_ff <= hold_partial_in;
      out_start_ff    <= out_start_in;
      out_end_ff      <= out_end_in;
      out_busy_ff     <= out_busy_in;
      out_partial_ff  <= out_partial_in;
      out_dropped_ff  <= out_dropped_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_interval_start_ns = out_start_ff;
   assign rsp_interval_end_ns   = out_end_ff;
   assign rsp_busy_ns           = out_busy_ff;
   assign rsp_is_partial        = out_partial_ff;
   assign rsp_dropped           = out_dropped_ff;
   assign rsp_last              = out_last_ff;

   // Between events the window end is exactly one interval past its start.
   `LBT_ASSERT_IMP(a_window_span, clock, reset, seq_idle, we_ff == wend_expect, "window end drift")
   // No record of a finished event may linger in the hold register.
   `LBT_ASSERT_IMP(a_hold_empty, clock, reset, seq_idle, !hold_valid_ff, "record left in hold")
   // The record count never passes the per-event budget.
   `LBT_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CAP_EVENT, "count over budget")
   // The divider only runs after the budget was exhausted.
   `LBT_ASSERT_IMP(a_div_skip, clock, reset, state_ff == S_DIV, skipped_ff, "divider without skip")

endmodule

// ===== test/tb_link_busy_time_per_interval_core.sv =====
// ----------------------------------------------------------------------------
// tb_link_busy_time_per_interval_core
// Self-checking bench for the link busy time core. Event beats go in on the
// req channel and window records come out on the rsp channel. Both sides
// idle and stall at random. A bench-side accounting model predicts every
// record, and each rsp beat is checked field by field against the oldest
// expected record. The interval register is only rewritten while the core
// is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_link_busy_time_per_interval_core;

   localparam int RECORD_CAP = lbt_pkg::MAX_RECORDS_DEF;
   localparam int IDLE_PCT = 19;
   // Covers the worst event: its states, the divider and its records.
   localparam int SETTLE_CYCLES = 120;
   localparam longint unsigned CYCLE_LIMIT = 500000;
   localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] BUSY_MAX = 64'h0000_00FF_FFFF_FFFF;

   typedef struct packed {
      lbt_pkg::time_type start_ns;
      lbt_pkg::time_type end_ns;
      lbt_pkg::busy_type busy_ns;
      logic              partial;
      logic              dropped;
      logic              last;
   } window_record_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   logic [1:0] req_mode = lbt_pkg::MODE_TICK;
   lbt_pkg::time_type req_now_ns = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   lbt_pkg::time_type rsp_interval_start_ns;
   lbt_pkg::time_type rsp_interval_end_ns;
   lbt_pkg::busy_type rsp_busy_ns;
   logic     rsp_is_partial;
   logic     rsp_dropped;
   logic     rsp_last;
   logic     csr_wr_en = 1'b0;
   lbt_pkg::busy_type csr_wr_data = '0;

   // Records the core still owes us, oldest first.
   window_record_type expected_records[$];
   int mismatches = 0;
   longint unsigned cycle_count = 0;
   // While set, neither side idles: a long back-to-back stretch.
   bit steady_flow = 1'b0;

   // Bench-side copy of the accounting state. The window end is kept in
   // 64 bits since it can run one interval past the largest time.
   lbt_pkg::busy_type acct_interval = lbt_pkg::RESET_INTERVAL;
   logic [63:0] acct_last_ns = '0;
   logic [63:0] acct_win_start = '0;
   logic [63:0] acct_win_end = {24'd0, lbt_pkg::RESET_INTERVAL};
   lbt_pkg::busy_type acct_busy = '0;
   logic        acct_sending = 1'b0;

   always #2 clock = ~clock;

   link_busy_time_per_interval_core #(
      .MAX_RECORDS(RECORD_CAP)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_now_ns            (req_now_ns),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_interval_start_ns (rsp_interval_start_ns),
      .rsp_interval_end_ns   (rsp_interval_end_ns),
      .rsp_busy_ns           (rsp_busy_ns),
      .rsp_is_partial        (rsp_is_partial),
      .rsp_dropped           (rsp_dropped),
      .rsp_last              (rsp_last),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Accounting model
   // ---------------------------------------------------------------------

   // A zero interval behaves as one ns. Rewriting re-times the open window.
   function automatic void set_interval(lbt_pkg::busy_type value);
      lbt_pkg::busy_type v;
      v = (value == '0) ? lbt_pkg::busy_type'(1) : value;
      acct_interval = v;
      acct_win_end = acct_win_start + {24'd0, v};
   endfunction

   // Adds transmit time between two instants, saturating at the counter max.
   function automatic void credit_busy(logic [63:0] from_ns, logic [63:0] to_ns);
      logic [63:0] span;
      span = to_ns - from_ns;
      if (acct_sending && to_ns > from_ns) begin
         if (span > BUSY_MAX || {24'd0, acct_busy} + span > BUSY_MAX) begin
            acct_busy = '1;
         end else begin
            acct_busy = acct_busy + span[lbt_pkg::BUSY_W-1:0];
         end
      end
   endfunction

   function automatic window_record_type make_record(logic [63:0] start_ns,
                                                     logic [63:0] end_ns,
                                                     lbt_pkg::busy_type busy,
                                                     logic partial);
      window_record_type r;
      r.start_ns = start_ns[lbt_pkg::TIME_W-1:0];
      r.end_ns = end_ns[lbt_pkg::TIME_W-1:0];
      r.busy_ns = busy;
      r.partial = partial;
      r.dropped = 1'b0;
      r.last = 1'b0;
      return r;
   endfunction

   // Applies one accepted event beat and queues the records it causes.
   function automatic void account_event(logic [1:0] mode, lbt_pkg::time_type now_in);
      window_record_type recs [0:RECORD_CAP];
      logic [63:0] now;
      logic [63:0] width;
      logic [63:0] steps;
      int cap;
      int count;
      int i;
      logic skipped;
      now = {1'b0, now_in};
      width = {24'd0, acct_interval};
      count = 0;
      skipped = 1'b0;
      // Finalize keeps one slot free for its partial record.
      cap = (mode == lbt_pkg::MODE_FINALIZE) ? RECORD_CAP - 1 : RECORD_CAP;
      // Time never runs backwards; an older stamp means no time elapsed.
      if (now < acct_last_ns) now = acct_last_ns;
      while (now >= acct_win_end && count < cap) begin
         credit_busy(acct_last_ns, acct_win_end);
         recs[count] = make_record(acct_win_start, acct_win_end, acct_busy, 1'b0);
         count++;
         acct_busy = '0;
         acct_last_ns = acct_win_end;
         acct_win_start = acct_win_end;
         acct_win_end = acct_win_end + width;
      end
      // Windows past the cap are skipped, busy time and all; the last record flags it.
      if (now >= acct_win_end) begin
         steps = (now - acct_win_end) / width + 64'd1;
         skipped = 1'b1;
         acct_win_end = acct_win_end + steps * width;
         acct_win_start = acct_win_end - width;
         acct_last_ns = acct_win_start;
         acct_busy = '0;
      end
      credit_busy(acct_last_ns, now);
      acct_last_ns = now;
      case (mode)
         lbt_pkg::MODE_TX_BEGIN: begin
            acct_sending = 1'b1;
         end
         lbt_pkg::MODE_TX_END: begin
            acct_sending = 1'b0;
         end
         lbt_pkg::MODE_FINALIZE: begin
            // The partial record leaves the busy counter running.
            if (now != acct_win_start) begin
               recs[count] = make_record(acct_win_start, now, acct_busy, 1'b1);
               count++;
            end
         end
         default: begin
         end
      endcase
      if (count > 0) begin
         recs[count-1].last = 1'b1;
         recs[count-1].dropped = skipped;
      end
      for (i = 0; i < count; i++) expected_records = {expected_records, recs[i]};
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stalls, in-order checking
   // ---------------------------------------------------------------------

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      window_record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            $error("unexpected record beat: start %0d end %0d busy %0d",
                   rsp_interval_start_ns, rsp_interval_end_ns, rsp_busy_ns);
            mismatches++;
         end else begin
            want = expected_records.pop_front();
            check_field("interval_start_ns", 64'(want.start_ns),
                        64'(rsp_interval_start_ns));
            check_field("interval_end_ns", 64'(want.end_ns), 64'(rsp_interval_end_ns));
            check_field("busy_ns", 64'(want.busy_ns), 64'(rsp_busy_ns));
            check_field("is_partial", 64'(want.partial), 64'(rsp_is_partial));
            check_field("dropped", 64'(want.dropped), 64'(rsp_dropped));
            check_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL link_busy_time_per_interval_core");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one event beat after a random idle gap and holds it until taken.
   task automatic send_event(logic [1:0] mode, logic [63:0] now);
      int gap;
      gap = 0;
      if (!steady_flow) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_now_ns <= now[lbt_pkg::TIME_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      account_event(mode, now[lbt_pkg::TIME_W-1:0]);
   endtask

   // Drains every owed record, then waits out any event still in flight
   // that produces nothing.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(lbt_pkg::busy_type value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      set_interval(value);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Next time stamp: mostly within the window or a few windows on, with
   // some jumps around the record cap, long skips and stale stamps.
   function automatic logic [63:0] next_time();
      logic [63:0] width;
      logic [63:0] base;
      logic [63:0] t;
      int r;
      width = {24'd0, acct_interval};
      base = acct_last_ns;
      r = $urandom_range(99);
      if (r < 55) begin
         t = base + rand64() % width;
      end else if (r < 80) begin
         t = base + width * 64'($urandom_range(3, 1)) + rand64() % width;
      end else if (r < 88) begin
         t = base + width * 64'($urandom_range(RECORD_CAP + 3, RECORD_CAP - 3))
             + rand64() % width;
      end else if (r < 92) begin
         t = base + width * 64'($urandom_range(1000, 100));
      end else if (r < 96) begin
         t = (base == 0) ? 64'd0 : rand64() % base;
      end else begin
         t = base;
      end
      return t;
   endfunction

   // Mostly proper begin/end alternation, with ticks, finalizes and the
   // odd repeated begin or end.
   function automatic logic [1:0] pick_mode();
      int r;
      logic [1:0] m;
      r = $urandom_range(99);
      if (r < 68) begin
         m = acct_sending ? lbt_pkg::MODE_TX_END : lbt_pkg::MODE_TX_BEGIN;
      end else if (r < 88) begin
         m = lbt_pkg::MODE_TICK;
      end else if (r < 95) begin
         m = lbt_pkg::MODE_FINALIZE;
      end else begin
         m = acct_sending ? lbt_pkg::MODE_TX_BEGIN : lbt_pkg::MODE_TX_END;
      end
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // All four modes on the reset interval, including a finalize at time
   // zero and one that lands exactly on a window start (no partial record).
   task automatic test_event_modes();
      send_event(lbt_pkg::MODE_TICK, 64'd0);
      send_event(lbt_pkg::MODE_FINALIZE, 64'd0);
      send_event(lbt_pkg::MODE_TX_BEGIN, 64'd10);
      send_event(lbt_pkg::MODE_TICK, 64'd50_000_000);
      send_event(lbt_pkg::MODE_TX_END, 64'd150_000_000);
      send_event(lbt_pkg::MODE_FINALIZE, 64'd180_000_000);
      send_event(lbt_pkg::MODE_FINALIZE, 64'd200_000_000);
   endtask

   // A stale stamp in the middle of a transmission adds no time.
   task automatic test_time_backwards();
      send_event(lbt_pkg::MODE_TX_BEGIN, 64'd250_000_000);
      send_event(lbt_pkg::MODE_TICK, 64'd120_000_000);
      send_event(lbt_pkg::MODE_TX_END, 64'd260_000_000);
   endtask

   // Shrinking the interval puts the window end behind the last event.
   task automatic test_shrunk_window();
      send_event(lbt_pkg::MODE_TX_BEGIN, 64'd270_000_000);
      write_interval(lbt_pkg::busy_type'(50_000_000));
      send_event(lbt_pkg::MODE_TX_END, 64'd330_000_000);
   endtask

   // Exactly at the record cap and just past it, for ordinary events and
   // for finalize, which has one slot less.
   task automatic test_record_cap();
      write_interval(lbt_pkg::busy_type'(10));
      send_event(lbt_pkg::MODE_TICK, acct_win_end + (RECORD_CAP - 1) * 10);
      send_event(lbt_pkg::MODE_TX_BEGIN, acct_win_end + RECORD_CAP * 10 + 4);
      send_event(lbt_pkg::MODE_FINALIZE, acct_win_end + 100 * 10 + 3);
      send_event(lbt_pkg::MODE_FINALIZE, acct_win_end + (RECORD_CAP - 2) * 10);
      send_event(lbt_pkg::MODE_TX_END, acct_last_ns);
   endtask

   // A written zero acts as a one-ns interval.
   task automatic test_zero_interval();
      write_interval('0);
      send_event(lbt_pkg::MODE_TICK, acct_win_start + 3);
   endtask

   // Largest interval, transmitting for all of it: busy reaches its max.
   task automatic test_full_window_busy();
      write_interval('1);
      send_event(lbt_pkg::MODE_TX_BEGIN, acct_win_start);
      send_event(lbt_pkg::MODE_TICK, acct_win_end);
      send_event(lbt_pkg::MODE_TX_END, acct_last_ns + 5);
   endtask

   task automatic test_random_traffic();
      lbt_pkg::busy_type spans [0:7];
      int p;
      int k;
      spans[0] = lbt_pkg::busy_type'($urandom_range(5000, 1));
      spans[1] = lbt_pkg::busy_type'(1);
      spans[2] = lbt_pkg::busy_type'($urandom_range(20000, 200));
      spans[3] = '1;
      spans[4] = lbt_pkg::busy_type'(rand64());
      spans[5] = '0;
      spans[6] = lbt_pkg::busy_type'(37);
      spans[7] = lbt_pkg::busy_type'($urandom_range(5000, 1));
      for (p = 0; p < 8; p++) begin
         write_interval(spans[p]);
         steady_flow = (p == 2);
         for (k = 0; k < 25; k++) send_event(pick_mode(), next_time());
      end
      steady_flow = 1'b0;
   endtask

   // Runs the clock up to the largest time stamp. This ends the timeline,
   // so it comes last.
   task automatic test_time_ceiling();
      write_interval(lbt_pkg::busy_type'(1000));
      send_event(lbt_pkg::MODE_TICK, TIME_MAX - 2500);
      send_event(lbt_pkg::MODE_TX_BEGIN, TIME_MAX - 7);
      send_event(lbt_pkg::MODE_FINALIZE, TIME_MAX);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_event_modes();
      test_time_backwards();
      test_shrunk_window();
      test_record_cap();
      test_zero_interval();
      test_full_window_busy();
      test_random_traffic();
      test_time_ceiling();
      wait_idle();
      if (mismatches == 0) begin
         $display("PASS link_busy_time_per_interval_core");
      end else begin
         $display("FAIL link_busy_time_per_interval_core");
      end
      $finish;
   end

endmodule
